// ===== src/greedy_change_dispenser_unit_macros.svh =====
// Assertion macros shared by the checker of the change dispenser.
// Depends on nothing; included by the checker file only.
`ifndef GREEDY_CHANGE_DISPENSER_UNIT_MACROS_SVH
`define GREEDY_CHANGE_DISPENSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define GCD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define GCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// ===== src/gcd_pkg.sv =====
// Shared types, constants and the denomination table of the change dispenser.
// Depends on nothing; imported by every module of the block.
package gcd_pkg;

   localparam int NUM_DENOMS = 14;
   localparam int IDX_W      = 4;
   localparam int DISP_W     = 8;
   localparam int AMT_W      = 24;
   localparam int STATUS_W   = 2;
   localparam int VALUE_W    = 18;
   localparam int NZ_W       = 4;
   localparam int SHIFT_W    = 3;
   localparam int DIV_X_W    = 20;
   localparam int RECIP_W    = 30;
   localparam int RECIP_SHIFT = 32;
   localparam int PROD_W     = DIV_X_W + RECIP_W;
   localparam int WIDE_W     = VALUE_W + DISP_W;

   localparam int REQ_TDATA_W   = 2 * AMT_W;
   localparam int RSP_FIELDS_W  = IDX_W + DISP_W + AMT_W + 1;
   localparam int RSP_TDATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_DISP_POS  = IDX_W;
   localparam int RSP_REM_POS   = IDX_W + DISP_W;
   localparam int RSP_EMPTY_POS = IDX_W + DISP_W + AMT_W;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [DISP_W-1:0]   REFILL_RESET     = 8'd5;
   localparam logic [IDX_W-1:0]    LAST_DENOM       = 4'(NUM_DENOMS - 1);
   localparam logic [NZ_W-1:0]     ALL_DENOMS       = 4'(NUM_DENOMS);
   localparam logic [STATUS_W-1:0] STATUS_PAID      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNDERPAID = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REFILLED  = 2'd2;

   typedef enum logic [1:0] {
      CMD_PAY,
      CMD_UNDERPAID,
      CMD_REFILL
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [AMT_W-1:0] change;
   } cmd_type;

   typedef struct packed {
      logic [IDX_W-1:0]    denom_index;
      logic [DISP_W-1:0]   dispensed;
      logic [AMT_W-1:0]    remaining_cents;
      logic [STATUS_W-1:0] status;
      logic                stock_empty;
      logic                last;
   } result_type;

   // Value of each denomination in cents, largest first.
   function automatic logic [VALUE_W-1:0] denom_value(input logic [IDX_W-1:0] idx);
      logic [VALUE_W-1:0] value;
      unique case (idx)
         4'd0:    value = 18'd200000;
         4'd1:    value = 18'd100000;
         4'd2:    value = 18'd50000;
         4'd3:    value = 18'd20000;
         4'd4:    value = 18'd10000;
         4'd5:    value = 18'd5000;
         4'd6:    value = 18'd2500;
         4'd7:    value = 18'd2000;
         4'd8:    value = 18'd1000;
         4'd9:    value = 18'd500;
         4'd10:   value = 18'd100;
         4'd11:   value = 18'd50;
         4'd12:   value = 18'd20;
         4'd13:   value = 18'd5;
         default: value = 18'd0;
      endcase
      return value;
   endfunction

   // Every value is 2**shift * 5**k; this gives the power-of-two part.
   function automatic logic [SHIFT_W-1:0] denom_shift(input logic [IDX_W-1:0] idx);
      logic [SHIFT_W-1:0] shift;
      unique case (idx)
         4'd0:    shift = 3'd6;
         4'd1:    shift = 3'd5;
         4'd2:    shift = 3'd4;
         4'd3:    shift = 3'd5;
         4'd4:    shift = 3'd4;
         4'd5:    shift = 3'd3;
         4'd6:    shift = 3'd2;
         4'd7:    shift = 3'd4;
         4'd8:    shift = 3'd3;
         4'd9:    shift = 3'd2;
         4'd10:   shift = 3'd2;
         4'd11:   shift = 3'd1;
         4'd12:   shift = 3'd2;
         4'd13:   shift = 3'd0;
         default: shift = 3'd0;
      endcase
      return shift;
   endfunction

   // ceil(2**32 / 5**k) for the odd part of each value; exact for quotients below 256.
   function automatic logic [RECIP_W-1:0] denom_recip(input logic [IDX_W-1:0] idx);
      logic [RECIP_W-1:0] recip;
      unique case (idx)
         4'd0:    recip = 30'd1374390;
         4'd1:    recip = 30'd1374390;
         4'd2:    recip = 30'd1374390;
         4'd3:    recip = 30'd6871948;
         4'd4:    recip = 30'd6871948;
         4'd5:    recip = 30'd6871948;
         4'd6:    recip = 30'd6871948;
         4'd7:    recip = 30'd34359739;
         4'd8:    recip = 30'd34359739;
         4'd9:    recip = 30'd34359739;
         4'd10:   recip = 30'd171798692;
         4'd11:   recip = 30'd171798692;
         4'd12:   recip = 30'd858993460;
         4'd13:   recip = 30'd858993460;
         default: recip = 30'd0;
      endcase
      return recip;
   endfunction

endpackage

// ===== src/gcd_front.sv =====
// Front end: accepts request words, computes the change and classifies the item.
// Depends on gcd_pkg.
module gcd_front import gcd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   output logic                   cmd_valid,
   output cmd_type                cmd,
   input  logic                   cmd_ready
);

   logic             valid_ff, valid_in;
   cmd_type          cmd_ff, cmd_in;
   logic [AMT_W-1:0] due, tendered;

   assign req_tready = !valid_ff || cmd_ready;

   always_comb begin
      due         = req_tdata[AMT_W-1:0];
      tendered    = req_tdata[REQ_TDATA_W-1:AMT_W];
      cmd_in.change = tendered - due;
      if (req_tuser) begin
         cmd_in.kind = CMD_REFILL;
      end else if (tendered < due) begin
         cmd_in.kind = CMD_UNDERPAID;
      end else begin
         cmd_in.kind = CMD_PAY;
      end
      valid_in = req_tready ? req_tvalid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_tvalid && req_tready) begin
         cmd_ff <= cmd_in;
      end
   end

   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

endmodule

// ===== src/gcd_queue.sv =====
// Short command queue between the front end and the dispensing engine.
// Depends on gcd_pkg.
module gcd_queue import gcd_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/gcd_back.sv =====
// Dispensing engine: holds the stocks, walks the denominations and drives the result register.
// Depends on gcd_pkg.
module gcd_back import gcd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  cmd_type           cmd,
   input  logic [DISP_W-1:0] refill_count,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output result_type        result
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   cmd_kind_type       kind_ff, kind_in;
   logic [AMT_W-1:0]   rem_ff, rem_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [DISP_W-1:0]  quot_ff, quot_in;
   logic [DISP_W-1:0]  stock_ff [NUM_DENOMS];
   logic [DISP_W-1:0]  stock_in [NUM_DENOMS];
   logic [NZ_W-1:0]    nz_ff, nz_in;
   logic               out_valid_ff, out_valid_in;
   result_type         out_ff, out_in;

   logic [VALUE_W-1:0] denom_cents;
   logic [DIV_X_W-1:0] scaled;
   logic [PROD_W-1:0]  product;
   logic [WIDE_W-1:0]  paid;
   logic [DISP_W-1:0]  quot_calc, give, stock_cur, stock_new;
   logic [AMT_W-1:0]   rem_new;
   logic [NZ_W-1:0]    nz_pay;
   logic               saturate, slot_free;

   assign cmd_ready = (state_ff == ST_IDLE);
   assign slot_free = !out_valid_ff || rsp_ready;

   always_comb begin
      stock_cur = '0;
      for (int i = 0; i < NUM_DENOMS; i++) begin
         if (idx_ff == IDX_W'(i)) begin
            stock_cur = stock_ff[i];
         end
      end
      denom_cents = denom_value(idx_ff);
      // Quotient by shift and reciprocal multiply; 256 or more pieces saturate,
      // since no stock holds more than 255.
      saturate  = (WIDE_W'(rem_ff) >= {denom_cents, DISP_W'(0)});
      scaled    = DIV_X_W'(rem_ff >> denom_shift(idx_ff));
      product   = PROD_W'(scaled) * PROD_W'(denom_recip(idx_ff));
      quot_calc = saturate ? '1 : product[RECIP_SHIFT +: DISP_W];
      // Cap by the stock and take the pieces given out from the change.
      give      = (quot_ff < stock_cur) ? quot_ff : stock_cur;
      paid      = WIDE_W'(give) * WIDE_W'(denom_cents);
      rem_new   = rem_ff - paid[AMT_W-1:0];
      stock_new = stock_cur - give;
      nz_pay    = nz_ff - NZ_W'((stock_cur != '0) && (stock_new == '0));
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      rem_in       = rem_ff;
      idx_in       = idx_ff;
      quot_in      = quot_ff;
      stock_in     = stock_ff;
      nz_in        = nz_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               kind_in  = cmd.kind;
               rem_in   = cmd.change;
               idx_in   = '0;
               quot_in  = '0;
               state_in = (cmd.kind == CMD_PAY) ? ST_DIVIDE : ST_EMIT;
            end
         end
         ST_DIVIDE: begin
            quot_in  = quot_calc;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               unique case (kind_ff)
                  CMD_PAY: begin
                     for (int i = 0; i < NUM_DENOMS; i++) begin
                        if (idx_ff == IDX_W'(i)) begin
                           stock_in[i] = stock_new;
                        end
                     end
                     nz_in                  = nz_pay;
                     rem_in                 = rem_new;
                     out_in.denom_index     = idx_ff;
                     out_in.dispensed       = give;
                     out_in.remaining_cents = rem_new;
                     out_in.status          = STATUS_PAID;
                     out_in.stock_empty     = (nz_pay == '0);
                     out_in.last            = (idx_ff == LAST_DENOM);
                     if (idx_ff == LAST_DENOM) begin
                        state_in = ST_IDLE;
                     end else begin
                        idx_in   = idx_ff + 1'b1;
                        quot_in  = '0;
                        state_in = ST_DIVIDE;
                     end
                  end
                  CMD_UNDERPAID: begin
                     out_in.denom_index     = '0;
                     out_in.dispensed       = '0;
                     out_in.remaining_cents = '0;
                     out_in.status          = STATUS_UNDERPAID;
                     out_in.stock_empty     = (nz_ff == '0);
                     out_in.last            = 1'b1;
                     state_in               = ST_IDLE;
                  end
                  CMD_REFILL: begin
                     for (int i = 0; i < NUM_DENOMS; i++) begin
                        stock_in[i] = refill_count;
                     end
                     nz_in                  = (refill_count != '0) ? ALL_DENOMS : '0;
                     out_in.denom_index     = '0;
                     out_in.dispensed       = '0;
                     out_in.remaining_cents = '0;
                     out_in.status          = STATUS_REFILLED;
                     out_in.stock_empty     = (refill_count == '0);
                     out_in.last            = 1'b1;
                     state_in               = ST_IDLE;
                  end
                  default: begin
                     out_valid_in = out_valid_ff && !rsp_ready;
                     state_in     = ST_IDLE;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         nz_ff        <= ALL_DENOMS;
         for (int i = 0; i < NUM_DENOMS; i++) begin
            stock_ff[i] <= REFILL_RESET;
         end
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         nz_ff        <= nz_in;
         stock_ff     <= stock_in;
      end
      kind_ff <= kind_in;
      rem_ff  <= rem_in;
      idx_ff  <= idx_in;
      quot_ff <= quot_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign result    = out_ff;

endmodule

// ===== src/greedy_change_dispenser_unit.sv =====
// Top level of the change dispenser: front end, command queue, dispensing engine.
// Depends on gcd_pkg, gcd_front, gcd_queue and gcd_back.
//
// Usage:
//   req channel: one word per item. tuser is the op (0 pay, 1 refill); tdata carries
//   the amount due and the amount tendered in cents. A pay word yields 14 rsp words,
//   largest denomination first; an underpaid pay word or a refill word yields one.
//   rsp channel: each word gives the denomination, the pieces given out, the change
//   still owed and the empty-stock flag; tuser is the status, tlast marks the final
//   word of an item.
//   csr port: csr_wen writes csr_wdata into the refill count. Write it only while
//   the block is idle.
// Timing: the front end registers each word and the queue holds it for the engine. The
//   engine walks each denomination in two steps (shift and reciprocal multiply for the
//   quotient, then the stock cap, stock update and result register load), and takes no
//   new item until the last denomination is done; underpaid and refill items need only
//   the second step. The second step waits while the result slot is still full.
// Reset: clears all handshake state, sets every stock and the refill count to 5.
// Stall: a word held on rsp freezes the engine once its next result is ready; the
//   queue and the front end keep taking req words until they fill up.
module greedy_change_dispenser_unit import gcd_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // amount_due_cents[23:0], tendered_cents[47:24]
   input  logic                   req_tuser,  // op[0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // denom_index[3:0], dispensed[11:4],
                                              // remaining_cents[35:12], stock_empty[36]
   output logic [STATUS_W-1:0]    rsp_tuser,  // status[1:0]
   output logic                   rsp_tlast,
   input  logic                   csr_wen,
   input  logic [DISP_W-1:0]      csr_wdata
);

   logic              front_valid, front_ready;
   cmd_type           front_cmd;
   logic              queue_valid, queue_ready;
   cmd_type           queue_cmd;
   result_type        result;
   logic [DISP_W-1:0] refill_ff;

   // Hold the refill count; the engine samples it when a refill word executes.
   always_ff @(posedge clock) begin
      if (reset) begin
         refill_ff <= REFILL_RESET;
      end else if (csr_wen) begin
         refill_ff <= csr_wdata;
      end
   end

   gcd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (front_valid),
      .cmd        (front_cmd),
      .cmd_ready  (front_ready)
   );

   gcd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_cmd),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_data   (queue_cmd)
   );

   gcd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (queue_valid),
      .cmd_ready    (queue_ready),
      .cmd          (queue_cmd),
      .refill_count (refill_ff),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .result       (result)
   );

   // Pack the result word; pad the top of tdata with zeros.
   assign rsp_tdata = {(RSP_TDATA_W - RSP_FIELDS_W)'(0), result.stock_empty,
                       result.remaining_cents, result.dispensed, result.denom_index};
   assign rsp_tuser = result.status;
   assign rsp_tlast = result.last;

endmodule

// ===== src/gcd_checker.sv =====
// Port-level checks of the change dispenser's result channel, bound to the top level.
// Depends on gcd_pkg and greedy_change_dispenser_unit_macros.svh.
`include "greedy_change_dispenser_unit_macros.svh"

module gcd_checker import gcd_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [STATUS_W-1:0]    rsp_tuser,
   input logic                   rsp_tlast
);

   // A stalled word holds still.
   `GCD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // A pay run ends exactly at the smallest denomination.
   `GCD_ASSERT_SAME(a_pay_last, clock, reset, rsp_tvalid && rsp_tuser == STATUS_PAID,
      rsp_tlast == (rsp_tdata[IDX_W-1:0] == LAST_DENOM))

   // Reject and refill words stand alone and carry no amounts.
   `GCD_ASSERT_SAME(a_single_word, clock, reset, rsp_tvalid && rsp_tuser != STATUS_PAID,
      rsp_tlast && rsp_tdata[RSP_EMPTY_POS-1:0] == '0)

   // Once the stock runs dry inside a pay run it stays dry for the rest of the run.
   `GCD_ASSERT_NEXT(a_empty_sticks, clock, reset,
      rsp_tvalid && rsp_tuser == STATUS_PAID && rsp_tdata[RSP_EMPTY_POS] && !rsp_tlast,
      !rsp_tvalid || rsp_tdata[RSP_EMPTY_POS])

endmodule

bind greedy_change_dispenser_unit gcd_checker u_gcd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
